// File: hdl/mpem_pkg.sv
// Shared constants and helpers for the MED prediction error mapper.
package mpem_pkg;

    localparam int MAX_WIDTH  = 4096;
    localparam int MAX_HEIGHT = 4096;
    localparam int PIX_W      = 8;
    localparam int ERR_W      = PIX_W + 1;
    localparam int SUM_W      = 33;
    localparam int DIM_W      = 13;
    localparam int ADDR_W     = $clog2(MAX_WIDTH);
    localparam int ROW_W      = $clog2(MAX_HEIGHT);

    // Configuration register indexes
    localparam logic CFG_IMAGE_WIDTH  = 1'b0;
    localparam logic CFG_IMAGE_HEIGHT = 1'b1;

    localparam logic [DIM_W-1:0] WIDTH_RESET  = DIM_W'(640);
    localparam logic [DIM_W-1:0] HEIGHT_RESET = DIM_W'(480);

    // Clamp a dimension to 1..Max and return it minus one
    function automatic logic [ADDR_W-1:0] width_last(input logic [DIM_W-1:0] v);
        logic [DIM_W-1:0] t;
        t = v - DIM_W'(1);
        if (v == '0) begin
            return '0;
        end else if (v > DIM_W'(MAX_WIDTH)) begin
            return ADDR_W'(MAX_WIDTH - 1);
        end
        return t[ADDR_W-1:0];
    endfunction

    function automatic logic [ROW_W-1:0] height_last(input logic [DIM_W-1:0] v);
        logic [DIM_W-1:0] t;
        t = v - DIM_W'(1);
        if (v == '0) begin
            return '0;
        end else if (v > DIM_W'(MAX_HEIGHT)) begin
            return ROW_W'(MAX_HEIGHT - 1);
        end
        return t[ROW_W-1:0];
    endfunction

endpackage

// File: hdl/med_prediction_error_mapper.sv
// Top level of the MED prediction error mapper with its line store.
//
//  channel  | valid    | stall    | payload
//  ---------+----------+----------+-----------------------------------------------
//  input    | i_valid  | o_stall  | i_pixel
//  output   | o_valid  | i_stall  | o_prediction_error, o_mapped_error,
//           |          |          | o_running_sum, o_frame_last
//  config   | i_cfg_we | -        | i_cfg_idx, i_cfg_data
//
// One word per cycle while i_stall is low; an accepted word is registered in stage one
// (line store read) and then loads the output register, from where it can leave.
// Same-column read and write-back overlap only on one-pixel rows; a bypass covers it.
// Reset clears counters, neighbor pixels, the sum and the pipeline valids; the line
// store is not cleared and is rewritten by the first row of each frame.
// An output stall holds the output word; input is taken until the middle stage fills.
module med_prediction_error_mapper
    import mpem_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_we,
    input  logic                    i_cfg_idx,
    input  logic [DIM_W-1:0]        i_cfg_data,
    input  logic                    i_valid,
    output logic                    o_stall,
    input  logic [PIX_W-1:0]        i_pixel,
    output logic                    o_valid,
    input  logic                    i_stall,
    output logic signed [ERR_W-1:0] o_prediction_error,
    output logic [ERR_W-1:0]        o_mapped_error,
    output logic [SUM_W-1:0]        o_running_sum,
    output logic                    o_frame_last
);

    logic [PIX_W-1:0]  mem [MAX_WIDTH];

    logic [DIM_W-1:0]  r_image_width, r_image_height;
    logic [ADDR_W-1:0] r_col;
    logic [ROW_W-1:0]  r_row;
    logic [PIX_W-1:0]  r_left, r_upleft;
    logic [SUM_W-1:0]  r_sum;

    logic              r_s1_valid;
    logic [PIX_W-1:0]  r_s1_pix;
    logic [ADDR_W-1:0] r_s1_col;
    logic              r_s1_first, r_s1_row0, r_s1_col0, r_s1_last;
    logic [PIX_W-1:0]  r_rdata;
    logic              r_fwd_hit;
    logic [PIX_W-1:0]  r_fwd_pix;

    logic              r_out_valid;
    logic [ERR_W-1:0]  r_err, r_mapped;
    logic [SUM_W-1:0]  r_out_sum;
    logic              r_out_last;

    logic              in_acc, adv, row_end, frame_end;
    logic [ADDR_W-1:0] col_last;
    logic [ROW_W-1:0]  row_last;
    logic [PIX_W-1:0]  above, mx, mn, pred;
    logic [PIX_W+1:0]  plane;
    logic [ERR_W-1:0]  n_err, n_mapped;
    logic [SUM_W-1:0]  n_sum;

    // Handshake and pipeline advance
    assign adv     = r_s1_valid && (!r_out_valid || !i_stall);
    assign o_stall = r_s1_valid && r_out_valid && i_stall;
    assign in_acc  = i_valid && !o_stall;

    // Frame position
    assign col_last  = width_last(r_image_width);
    assign row_last  = height_last(r_image_height);
    assign row_end   = (r_col >= col_last);
    assign frame_end = row_end && (r_row >= row_last);

    // Write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_width  <= WIDTH_RESET;
            r_image_height <= HEIGHT_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_IMAGE_WIDTH:  r_image_width  <= i_cfg_data;
                CFG_IMAGE_HEIGHT: r_image_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Advance column and row counters on each accepted word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (in_acc) begin
            if (row_end) begin
                r_col <= '0;
                r_row <= frame_end ? '0 : r_row + ROW_W'(1);
            end else begin
                r_col <= r_col + ADDR_W'(1);
            end
        end
    end

    // Line store: read at accept, write back when the word leaves stage one
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_rdata <= mem[r_col];
        end
        if (adv) begin
            mem[r_s1_col] <= r_s1_pix;
        end
    end

    // Stage one registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_acc) begin
            r_s1_valid <= 1'b1;
        end else if (adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_pix   <= i_pixel;
            r_s1_col   <= r_col;
            r_s1_first <= (r_col == '0) && (r_row == '0);
            r_s1_row0  <= (r_row == '0);
            r_s1_col0  <= (r_col == '0);
            r_s1_last  <= frame_end;
            // bypass the write that lands on the column being read
            r_fwd_hit  <= adv && (r_s1_col == r_col);
            r_fwd_pix  <= r_s1_pix;
        end
    end

    // Predict, take the error and map it
    always_comb begin
        above = r_fwd_hit ? r_fwd_pix : r_rdata;
        mx    = (r_left > above) ? r_left : above;
        mn    = (r_left < above) ? r_left : above;
        plane = {2'b00, r_left} + {2'b00, above} - {2'b00, r_upleft};
        if (r_s1_row0) begin
            pred = r_left;
        end else if (r_s1_col0) begin
            pred = above;
        end else if (r_upleft >= mx) begin
            pred = mn;
        end else if (r_upleft <= mn) begin
            pred = mx;
        end else begin
            pred = plane[PIX_W-1:0];
        end
        if (r_s1_first) begin
            n_err    = {1'b0, r_s1_pix};
            n_mapped = {1'b0, r_s1_pix};
            n_sum    = SUM_W'(r_s1_pix);
        end else begin
            n_err    = {1'b0, pred} - {1'b0, r_s1_pix};
            n_mapped = n_err[ERR_W-1] ? ~{n_err[PIX_W-1:0], 1'b0}
                                      :  {n_err[PIX_W-1:0], 1'b0};
            n_sum    = r_sum + SUM_W'(n_mapped);
        end
    end

    // Update neighbor pixels and the running sum
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left   <= '0;
            r_upleft <= '0;
            r_sum    <= '0;
        end else if (adv) begin
            r_left   <= r_s1_pix;
            r_upleft <= above;
            r_sum    <= n_sum;
        end
    end

    // Output register: load on advance, drop once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_err      <= n_err;
            r_mapped   <= n_mapped;
            r_out_sum  <= n_sum;
            r_out_last <= r_s1_last;
        end
    end

    assign o_valid            = r_out_valid;
    assign o_prediction_error = r_err;
    assign o_mapped_error     = r_mapped;
    assign o_running_sum      = r_out_sum;
    assign o_frame_last       = r_out_last;

endmodule

// File: hdl/mpem_checker.sv
// Port-level assertions for the MED prediction error mapper, bound to the top level.
module mpem_checker
    import mpem_pkg::*;
(
    input logic                    i_clk,
    input logic                    i_rst_n,
    input logic                    i_cfg_we,
    input logic                    i_cfg_idx,
    input logic [DIM_W-1:0]        i_cfg_data,
    input logic                    i_valid,
    input logic                    o_stall,
    input logic [PIX_W-1:0]        i_pixel,
    input logic                    o_valid,
    input logic                    i_stall,
    input logic signed [ERR_W-1:0] o_prediction_error,
    input logic [ERR_W-1:0]        o_mapped_error,
    input logic [SUM_W-1:0]        o_running_sum,
    input logic                    o_frame_last
);

    // No output word right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

    // A stalled output word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_prediction_error)
            && $stable(o_mapped_error) && $stable(o_running_sum)
            && $stable(o_frame_last))
        else $error("stalled output word changed");

    // Input stall only comes from a full, stalled output
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid && i_stall)
        else $error("input stalled without output back-pressure");

    // Negative errors map to the odd code
    a_neg_map: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_prediction_error[ERR_W-1] |->
            o_mapped_error == ~{o_prediction_error[PIX_W-1:0], 1'b0})
        else $error("negative error mapped wrongly");

endmodule

bind med_prediction_error_mapper mpem_checker u_mpem_checker (.*);
